// File: src/bchd_pkg.sv
`timescale 1ns / 1ps

package bchd_pkg;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_BRIGHT_STEP = 3'd1,
    EV_NEXT_SUB    = 3'd2,
    EV_NEXT_ANIM   = 3'd3,
    EV_PARTY       = 3'd4,
    EV_SECURITY    = 3'd5,
    EV_FULL_BRIGHT = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    REG_HOLD_PERIOD  = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_HOLD_REPEATS = 2'd2
  } reg_index_e;

  localparam logic        ACT_TICK = 1'b0;
  localparam logic        ACT_EDGE = 1'b1;
  localparam logic        PIN_PRESSED = 1'b0;

  localparam logic [15:0] HOLD_PERIOD_RST  = 16'd150;
  localparam logic [15:0] CLICK_WINDOW_RST = 16'd400;
  localparam logic [3:0]  HOLD_REPEATS_RST = 4'd5;

  localparam logic [7:0]  CLICKS_SUB      = 8'd1;
  localparam logic [7:0]  CLICKS_ANIM     = 8'd2;
  localparam logic [7:0]  CLICKS_PARTY    = 8'd4;
  localparam logic [7:0]  CLICKS_SECURITY = 8'd5;
  localparam logic [7:0]  CLICKS_FULL     = 8'd10;

  typedef struct packed {
    logic [15:0] hold_period;
    logic [15:0] click_window;
    logic [3:0]  hold_repeats;
  } cfg_t;

  typedef struct packed {
    logic        hold_running;
    logic [15:0] hold_elapsed;
    logic [3:0]  hold_period_count;
    logic        held_flag;
    logic        window_running;
    logic [15:0] window_elapsed;
    logic [7:0]  click_count;
  } state_t;

endpackage

// File: src/bchd_core.sv
`timescale 1ns / 1ps

module bchd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               action_i,
  input  logic               pin_level_i,
  input  bchd_pkg::cfg_t     cfg_i,
  output bchd_pkg::event_e   event_o
);

  bchd_pkg::state_t st_q, st_d;
  bchd_pkg::event_e hold_ev, win_ev;
  logic [16:0]      hold_inc, win_inc;
  logic [3:0]       cnt_inc;

  function automatic bchd_pkg::event_e dispatch(input logic [7:0] clicks, input logic held);
    bchd_pkg::event_e ev;
    ev = bchd_pkg::EV_NONE;
    case (clicks)
      bchd_pkg::CLICKS_SUB:      ev = held ? bchd_pkg::EV_NONE : bchd_pkg::EV_NEXT_SUB;
      bchd_pkg::CLICKS_ANIM:     ev = held ? bchd_pkg::EV_NONE : bchd_pkg::EV_NEXT_ANIM;
      bchd_pkg::CLICKS_PARTY:    ev = bchd_pkg::EV_PARTY;
      bchd_pkg::CLICKS_SECURITY: ev = bchd_pkg::EV_SECURITY;
      bchd_pkg::CLICKS_FULL:     ev = bchd_pkg::EV_FULL_BRIGHT;
      default:                   ev = bchd_pkg::EV_NONE;
    endcase
    return ev;
  endfunction

  assign hold_inc = {1'b0, st_q.hold_elapsed} + 17'd1;
  assign win_inc  = {1'b0, st_q.window_elapsed} + 17'd1;
  assign cnt_inc  = st_q.hold_period_count + 4'd1;

  always_comb begin
    st_d    = st_q;
    hold_ev = bchd_pkg::EV_NONE;
    win_ev  = bchd_pkg::EV_NONE;
    if (action_i == bchd_pkg::ACT_TICK) begin
      if (st_q.hold_running) begin
        if (hold_inc >= {1'b0, cfg_i.hold_period}) begin
          st_d.hold_elapsed      = '0;
          st_d.hold_period_count = cnt_inc;
          if (cnt_inc >= cfg_i.hold_repeats) begin
            st_d.held_flag         = 1'b1;
            st_d.hold_period_count = '0;
            hold_ev                = bchd_pkg::EV_BRIGHT_STEP;
          end
        end else begin
          st_d.hold_elapsed = hold_inc[15:0];
        end
      end
      if (st_q.window_running) begin
        if (win_inc >= {1'b0, cfg_i.click_window}) begin
          st_d.window_running = 1'b0;
          st_d.window_elapsed = '0;
          // held flag as left by the hold timer on this same tick
          win_ev              = dispatch(st_q.click_count, st_d.held_flag);
          st_d.click_count    = '0;
        end else begin
          st_d.window_elapsed = win_inc[15:0];
        end
      end
    end else if (pin_level_i == bchd_pkg::PIN_PRESSED) begin
      st_d.window_running    = 1'b0;
      st_d.window_elapsed    = '0;
      st_d.held_flag         = 1'b0;
      st_d.hold_period_count = '0;
      st_d.hold_running      = 1'b1;
      st_d.hold_elapsed      = '0;
    end else begin
      st_d.hold_running   = 1'b0;
      st_d.hold_elapsed   = '0;
      st_d.window_running = 1'b1;
      st_d.window_elapsed = '0;
      st_d.click_count    = st_q.click_count + 8'd1;
    end
  end

  assign event_o = (hold_ev != bchd_pkg::EV_NONE) ? hold_ev : win_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

endmodule

// File: src/button_click_hold_decoder.sv
`timescale 1ns / 1ps

// Push-button gesture decoder. Each slave beat is a 1 ms tick (tuser 0) or a pin
// edge (tuser 1, tdata bit 0 = new level, 0 pressed); each one yields exactly one
// master beat with the event code (0 when nothing happened). One beat is taken
// every cycle while the master side is ready; a beat is captured in the input
// register and its result is then held in the output register. Registers: 0 hold
// period, 1 click window (both in ticks), 2 hold periods per brightness step;
// write them only while no beats are in flight.
module button_click_hold_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] event_code, [7:3] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  bchd_pkg::cfg_t   cfg_q;
  bchd_pkg::event_e core_ev;
  logic             in_valid_q, in_action_q, in_pin_q;
  logic             out_valid_q;
  logic [2:0]       out_event_q;
  logic             out_free, advance, s_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_period  <= bchd_pkg::HOLD_PERIOD_RST;
      cfg_q.click_window <= bchd_pkg::CLICK_WINDOW_RST;
      cfg_q.hold_repeats <= bchd_pkg::HOLD_REPEATS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bchd_pkg::REG_HOLD_PERIOD:  cfg_q.hold_period  <= cfg_data_i;
        bchd_pkg::REG_CLICK_WINDOW: cfg_q.click_window <= cfg_data_i;
        bchd_pkg::REG_HOLD_REPEATS: cfg_q.hold_repeats <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_free)      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_action_q <= s_axis_tuser[0];
      in_pin_q    <= s_axis_tdata[0];
    end
    if (advance) begin
      out_event_q <= core_ev;
    end
  end

  bchd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .action_i    (in_action_q),
    .pin_level_i (in_pin_q),
    .cfg_i       (cfg_q),
    .event_o     (core_ev)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_event_q};

endmodule

// File: src/bchd_checker.sv
`timescale 1ns / 1ps

module bchd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // output beat stalled by the sink keeps its event
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0 &&
                      m_axis_tdata[2:0] <= bchd_pkg::EV_FULL_BRIGHT)
    else $error("bad event code on output");

  // empty output register means the input side can never be blocked
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with free output register");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind button_click_hold_decoder bchd_checker u_bchd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bchd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600_000;
  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PRINT_CAP    = 50;

  localparam logic ROW_BEAT     = 1'b0;
  localparam logic ROW_CFG      = 1'b1;
  localparam logic TYPED        = 1'b1;
  localparam logic PREDICTED    = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  typedef struct packed {
    logic        is_cfg;
    reg_index_e  idx;
    logic [15:0] value;
    logic        act;
    logic        lvl;
    logic        pinned;
    event_e      code;
  } dir_row_t;

  // Directed opener: zero registers, hold flag suppressing one click,
  // press while pressed, party, extremes and a period lowered under a running hold.
  localparam dir_row_t DIRECTED_ROWS [35] = '{
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, PIN_PRESSED,  TYPED,     EV_NONE},
    '{ROW_CFG,  REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_CFG,  REG_HOLD_REPEATS, 16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b1,         TYPED,     EV_BRIGHT_STEP},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         TYPED,     EV_BRIGHT_STEP},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, PIN_PRESSED,  TYPED,     EV_NONE},
    '{ROW_CFG,  REG_HOLD_REPEATS, 16'd15,    ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_CFG,  REG_CLICK_WINDOW, 16'd1,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, PIN_PRESSED,  TYPED,     EV_NONE},
    '{ROW_CFG,  REG_HOLD_REPEATS, 16'd1,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, PIN_PRESSED,  TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_CFG,  REG_CLICK_WINDOW, 16'd2,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_CFG,  REG_HOLD_PERIOD,  16'd65535, ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_CFG,  REG_CLICK_WINDOW, 16'd65535, ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, PIN_PRESSED,  TYPED,     EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_CFG,  REG_HOLD_PERIOD,  16'd1,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_TICK, 1'b0,         PREDICTED, EV_NONE},
    '{ROW_BEAT, REG_HOLD_PERIOD,  16'd0,     ACT_EDGE, LVL_RELEASED, TYPED,     EV_NONE}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [0] pin_level, [7:1] zero
  logic [0:0]  s_axis_tuser  = '0;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [2:0] event_code, [7:3] zero
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  // typed expectation travels alongside the beat it belongs to
  logic        pin_exp_valid = 1'b0;
  event_e      pin_exp_code  = EV_NONE;

  state_t      button_now;
  cfg_t        decoder_cfg;
  event_e      pending_events[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;
  int unsigned tx_max         = 8;
  int unsigned rx_max         = 8;
  int unsigned rx_hold        = 0;

  button_click_hold_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advances the shadow button state by one tick or edge and returns the event.
  function automatic event_e next_gesture_event(input logic act, input logic lvl);
    event_e      hold_ev;
    event_e      win_ev;
    logic [16:0] nxt;
    hold_ev = EV_NONE;
    win_ev  = EV_NONE;
    if (act == ACT_TICK) begin
      if (button_now.hold_running) begin
        nxt = button_now.hold_elapsed + 17'd1;
        if (nxt >= {1'b0, decoder_cfg.hold_period}) begin
          button_now.hold_elapsed = '0;
          button_now.hold_period_count = button_now.hold_period_count + 4'd1;
          if (button_now.hold_period_count >= decoder_cfg.hold_repeats) begin
            button_now.held_flag = 1'b1;
            button_now.hold_period_count = '0;
            hold_ev = EV_BRIGHT_STEP;
          end
        end else begin
          button_now.hold_elapsed = nxt[15:0];
        end
      end
      if (button_now.window_running) begin
        nxt = button_now.window_elapsed + 17'd1;
        if (nxt >= {1'b0, decoder_cfg.click_window}) begin
          button_now.window_running = 1'b0;
          button_now.window_elapsed = '0;
          case (button_now.click_count)
            CLICKS_SUB:      win_ev = button_now.held_flag ? EV_NONE : EV_NEXT_SUB;
            CLICKS_ANIM:     win_ev = button_now.held_flag ? EV_NONE : EV_NEXT_ANIM;
            CLICKS_PARTY:    win_ev = EV_PARTY;
            CLICKS_SECURITY: win_ev = EV_SECURITY;
            CLICKS_FULL:     win_ev = EV_FULL_BRIGHT;
            default:         win_ev = EV_NONE;
          endcase
          button_now.click_count = '0;
        end else begin
          button_now.window_elapsed = nxt[15:0];
        end
      end
    end else if (lvl == PIN_PRESSED) begin
      button_now.window_running    = 1'b0;
      button_now.window_elapsed    = '0;
      button_now.held_flag         = 1'b0;
      button_now.hold_period_count = '0;
      button_now.hold_running      = 1'b1;
      button_now.hold_elapsed      = '0;
    end else begin
      button_now.hold_running   = 1'b0;
      button_now.hold_elapsed   = '0;
      button_now.window_running = 1'b1;
      button_now.window_elapsed = '0;
      button_now.click_count    = button_now.click_count + 8'd1;
    end
    return (hold_ev != EV_NONE) ? hold_ev : win_ev;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch @%0d: %s: got %0d, want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_beat(input logic act, input logic lvl, input logic pinned,
                           input event_e code);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, lvl};
    pin_exp_valid <= pinned;
    pin_exp_code  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HOLD_PERIOD:  decoder_cfg.hold_period  = val;
      REG_CLICK_WINDOW: decoder_cfg.click_window = val;
      REG_HOLD_REPEATS: decoder_cfg.hold_repeats = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // 0 and the top value now and then, otherwise something short
  function automatic logic [15:0] draw_reg_value(input logic [15:0] top,
                                                 input int unsigned short_top);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return top;
    return 16'($urandom_range(1, short_top));
  endfunction

  // Press/hold/release a number of times, then let the window run out unless it is longer than 60 ticks.
  task automatic play_clicks(input int unsigned clicks);
    int unsigned hp;
    int unsigned cw;
    int unsigned span;
    int unsigned ticks;
    hp   = (decoder_cfg.hold_period == 0) ? 1 : decoder_cfg.hold_period;
    cw   = (decoder_cfg.click_window == 0) ? 1 : decoder_cfg.click_window;
    span = hp * ((decoder_cfg.hold_repeats == 0) ? 1 : decoder_cfg.hold_repeats);
    for (int c = 0; c < clicks; c++) begin
      send_beat(ACT_EDGE, PIN_PRESSED, TYPED, EV_NONE);
      if ($urandom_range(0, 15) == 0)
        send_beat(ACT_EDGE, PIN_PRESSED, TYPED, EV_NONE);
      ticks = ($urandom_range(0, 3) == 0) ? span + $urandom_range(0, span)
                                          : $urandom_range(0, 2);
      if (ticks > 70) ticks = 70;
      repeat (ticks) send_beat(ACT_TICK, 1'($urandom_range(0, 1)), PREDICTED, EV_NONE);
      send_beat(ACT_EDGE, LVL_RELEASED, TYPED, EV_NONE);
      // a bouncing release counts as one more click
      if ($urandom_range(0, 15) == 0)
        send_beat(ACT_EDGE, LVL_RELEASED, TYPED, EV_NONE);
      if (c + 1 < clicks)
        ticks = $urandom_range(0, (cw > 20) ? 19 : cw - 1);
      else
        ticks = (cw > 60) ? $urandom_range(0, 10) : cw + $urandom_range(0, 3);
      repeat (ticks) send_beat(ACT_TICK, 1'($urandom_range(0, 1)), PREDICTED, EV_NONE);
    end
  endtask

  always @(posedge clk_i) begin
    event_e predicted;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted = next_gesture_event(s_axis_tuser[0], s_axis_tdata[0]);
      pending_events.push_back(pin_exp_valid ? pin_exp_code : predicted);
    end
  end

  always @(posedge clk_i) begin
    event_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("result beat with nothing pending", m_axis_tdata, 8'd0);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata !== {5'd0, want})
          flag_mismatch("event_code", m_axis_tdata, {5'd0, want});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_hold = $urandom_range(0, rx_max);
      m_axis_tready <= (rx_hold == 0);
    end else if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= (rx_hold == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    // falling edge at time zero so the asynchronous reset actually fires
    rst_ni      <= 1'b0;
    button_now  = '0;
    decoder_cfg = {HOLD_PERIOD_RST, CLICK_WINDOW_RST, HOLD_REPEATS_RST};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].is_cfg) begin
        drain_results();
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
      end else begin
        send_beat(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].lvl, DIRECTED_ROWS[r].pinned,
                  DIRECTED_ROWS[r].code);
      end
    end

    // close the open window, then 266 clicks wrap the count around to ten
    drain_results();
    write_reg(REG_CLICK_WINDOW, 16'd3);
    repeat (3) send_beat(ACT_TICK, 1'b0, PREDICTED, EV_NONE);
    repeat (266) send_beat(ACT_EDGE, LVL_RELEASED, TYPED, EV_NONE);
    repeat (3) send_beat(ACT_TICK, 1'b1, PREDICTED, EV_NONE);

    while (beats_sent < ITEM_TARGET) begin
      drain_results();
      if ($urandom_range(0, 1))
        write_reg(REG_HOLD_PERIOD, draw_reg_value(16'd65535, 5));
      if ($urandom_range(0, 1))
        write_reg(REG_CLICK_WINDOW, draw_reg_value(16'd65535, 25));
      if ($urandom_range(0, 1))
        write_reg(REG_HOLD_REPEATS, draw_reg_value(16'd15, 4));
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 30))
          send_beat(($urandom_range(0, 3) == 0) ? ACT_EDGE : ACT_TICK,
                    1'($urandom_range(0, 1)), PREDICTED, EV_NONE);
      end else begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: play_clicks(1);
          1: play_clicks(2);
          2: play_clicks(4);
          3: play_clicks(5);
          4: play_clicks(10);
          5: play_clicks(3);
          default: play_clicks($urandom_range(1, 12));
        endcase
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
